// ----- rtl/apt2d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt2d_pkg
// Shared widths, types and register indexes of the 2-D affine point transform.
// ----------------------------------------------------------------------------
package apt2d_pkg;

  localparam int VEC_LEN        = 3;
  localparam int COORD_WIDTH    = 16;
  localparam int COEF_WIDTH     = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int OUT_WIDTH      = 24;
  localparam int NUM_REGS       = 6;

  localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
  localparam int RND_WIDTH  = PROD_WIDTH + 1 - COEF_FRAC_BITS;
  localparam int SUM_WIDTH  = RND_WIDTH + 2;

  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 5;
  localparam int REG_IDX_WIDTH  = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [RND_WIDTH-1:0]   rnd_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [OUT_WIDTH-1:0]   out_t;

  localparam logic signed [PROD_WIDTH:0] ROUND_HALF =
    (PROD_WIDTH+1)'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam sum_t SUM_HI = SUM_WIDTH'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
  localparam sum_t SUM_LO = SUM_WIDTH'(-(64'sd1 <<< (OUT_WIDTH - 1)));
  localparam out_t OUT_HI = OUT_WIDTH'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
  localparam out_t OUT_LO = OUT_WIDTH'(-(64'sd1 <<< (OUT_WIDTH - 1)));

  localparam coef_t COEF_ONE = COEF_WIDTH'(64'sd1 <<< COEF_FRAC_BITS);

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_COEF_XX = 3'd0,
    REG_COEF_XY = 3'd1,
    REG_COEF_YX = 3'd2,
    REG_COEF_YY = 3'd3,
    REG_TRANS_X = 3'd4,
    REG_TRANS_Y = 3'd5
  } reg_idx_t;

endpackage

// ----- rtl/apt2d_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt2d_if
// Valid/ready channels: input points and transformed results.
// ----------------------------------------------------------------------------
interface apt2d_point_if import apt2d_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_in;
  coord_t y_in;
  coord_t w_in;
  logic   last_point;

  modport source (output valid, x_in, y_in, w_in, last_point, input ready);
  modport sink   (input valid, x_in, y_in, w_in, last_point, output ready);
endinterface

interface apt2d_result_if import apt2d_pkg::*; ();
  logic   valid;
  logic   ready;
  out_t   x_out;
  out_t   y_out;
  coord_t w_out;
  logic   last_point_out;
  logic   saturated;

  modport source (output valid, x_out, y_out, w_out, last_point_out, saturated,
                  input ready);
  modport sink   (input valid, x_out, y_out, w_out, last_point_out, saturated,
                  output ready);
endinterface

// ----- rtl/apt2d_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt2d_lane
// One vector element: two products against its matrix row, each rounded.
// ----------------------------------------------------------------------------
module apt2d_lane import apt2d_pkg::*; (
  input  logic   clk,
  input  logic   en_mul,
  input  logic   en_rnd,
  input  coord_t coord,
  input  coef_t  coef_x,
  input  coef_t  coef_y,
  output rnd_t   rnd_x,
  output rnd_t   rnd_y
);

  prod_t prod_x;
  prod_t prod_y;
  logic signed [PROD_WIDTH:0] bias_x;
  logic signed [PROD_WIDTH:0] bias_y;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_x <= PROD_WIDTH'(coord) * PROD_WIDTH'(coef_x);
      prod_y <= PROD_WIDTH'(coord) * PROD_WIDTH'(coef_y);
    end
  end

  // floor(p + 0.5): add half an lsb, arithmetic shift
  always_comb begin
    bias_x = (PROD_WIDTH+1)'(prod_x) + ROUND_HALF;
    bias_y = (PROD_WIDTH+1)'(prod_y) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en_rnd) begin
      rnd_x <= RND_WIDTH'(bias_x >>> COEF_FRAC_BITS);
      rnd_y <= RND_WIDTH'(bias_y >>> COEF_FRAC_BITS);
    end
  end

endmodule

// ----- rtl/apt2d_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt2d_merge
// Sums the rounded lane products per axis and clamps to the output width.
// ----------------------------------------------------------------------------
module apt2d_merge import apt2d_pkg::*; (
  input  logic clk,
  input  logic en,
  input  rnd_t rnd_x [VEC_LEN],
  input  rnd_t rnd_y [VEC_LEN],
  output out_t x_out,
  output out_t y_out,
  output logic saturated
);

  sum_t sum_x;
  sum_t sum_y;
  out_t x_next;
  out_t y_next;
  logic sat_x;
  logic sat_y;

  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int k = 0; k < VEC_LEN; k++) begin
      sum_x = sum_x + SUM_WIDTH'(rnd_x[k]);
      sum_y = sum_y + SUM_WIDTH'(rnd_y[k]);
    end

    sat_x  = 1'b1;
    if (sum_x > SUM_HI) begin
      x_next = OUT_HI;
    end else if (sum_x < SUM_LO) begin
      x_next = OUT_LO;
    end else begin
      x_next = OUT_WIDTH'(sum_x);
      sat_x  = 1'b0;
    end

    sat_y  = 1'b1;
    if (sum_y > SUM_HI) begin
      y_next = OUT_HI;
    end else if (sum_y < SUM_LO) begin
      y_next = OUT_LO;
    end else begin
      y_next = OUT_WIDTH'(sum_y);
      sat_y  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out     <= x_next;
      y_out     <= y_next;
      saturated <= sat_x | sat_y;
    end
  end

endmodule

// ----- rtl/affine_point_transform_2d_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_transform_2d_top
// Homogeneous 2-D affine transform of a point stream, APB-programmed matrix.
//
//   channel  dir  handshake       payload
//   pt       in   valid/ready     x_in, y_in, w_in, last_point
//   res      out  valid/ready     x_out, y_out, w_out, last_point_out, saturated
//   apb      in   psel/penable    coef_xx..trans_y at 0x00..0x14
//
// one point per cycle while res is ready; the pipe is a multiply register,
// a rounding register and a sum/clamp output register, with one lane per element
// reset (rst, synchronous) empties the pipe and loads the identity matrix
// a stall on res holds the output; the pipe keeps filling its empty stages
// ----------------------------------------------------------------------------
module affine_point_transform_2d_top import apt2d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  apt2d_point_if.sink               pt,
  apt2d_result_if.source            res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  coef_t coef [VEC_LEN][2];

  logic valid1;
  logic valid2;
  logic valid3;
  logic en1;
  logic en2;
  logic en3;

  coord_t w1;
  coord_t w2;
  logic   last1;
  logic   last2;

  coord_t coord [VEC_LEN];
  rnd_t   rnd_x [VEC_LEN];
  rnd_t   rnd_y [VEC_LEN];

  reg_idx_t reg_idx;
  logic     wr_req;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
  assign wr_req  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0][0] <= COEF_ONE;
      coef[0][1] <= '0;
      coef[1][0] <= '0;
      coef[1][1] <= COEF_ONE;
      coef[2][0] <= '0;
      coef[2][1] <= '0;
    end else if (wr_req) begin
      unique case (reg_idx)
        REG_COEF_XX: coef[0][0] <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_XY: coef[0][1] <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_YX: coef[1][0] <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_YY: coef[1][1] <= pwdata[COEF_WIDTH-1:0];
        REG_TRANS_X: coef[2][0] <= pwdata[COEF_WIDTH-1:0];
        REG_TRANS_Y: coef[2][1] <= pwdata[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COEF_XX: prdata = APB_DATA_WIDTH'(coef[0][0]);
      REG_COEF_XY: prdata = APB_DATA_WIDTH'(coef[0][1]);
      REG_COEF_YX: prdata = APB_DATA_WIDTH'(coef[1][0]);
      REG_COEF_YY: prdata = APB_DATA_WIDTH'(coef[1][1]);
      REG_TRANS_X: prdata = APB_DATA_WIDTH'(coef[2][0]);
      REG_TRANS_Y: prdata = APB_DATA_WIDTH'(coef[2][1]);
      default:     prdata = '0;
    endcase
  end

  // each stage moves when the one after it is empty or moving
  assign en3      = ~valid3 | res.ready;
  assign en2      = ~valid2 | en3;
  assign en1      = ~valid1 | en2;
  assign pt.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (en1) valid1 <= pt.valid;
      if (en2) valid2 <= valid1;
      if (en3) valid3 <= valid2;
    end
  end

  // w and last travel beside the lanes
  always_ff @(posedge clk) begin
    if (en1) begin
      w1    <= pt.w_in;
      last1 <= pt.last_point;
    end
    if (en2) begin
      w2    <= w1;
      last2 <= last1;
    end
    if (en3) begin
      res.w_out          <= w2;
      res.last_point_out <= last2;
    end
  end

  assign coord[0] = pt.x_in;
  assign coord[1] = pt.y_in;
  assign coord[2] = pt.w_in;

  for (genvar k = 0; k < VEC_LEN; k++) begin : g_lane
    apt2d_lane u_lane (
      .clk    (clk),
      .en_mul (en1),
      .en_rnd (en2),
      .coord  (coord[k]),
      .coef_x (coef[k][0]),
      .coef_y (coef[k][1]),
      .rnd_x  (rnd_x[k]),
      .rnd_y  (rnd_y[k])
    );
  end

  apt2d_merge u_merge (
    .clk       (clk),
    .en        (en3),
    .rnd_x     (rnd_x),
    .rnd_y     (rnd_y),
    .x_out     (res.x_out),
    .y_out     (res.y_out),
    .saturated (res.saturated)
  );

  assign res.valid = valid3;

endmodule

// ----- tb/apt2d_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt2d_result_checker
// Watches the point, result and APB channels of the affine point transform.
// Keeps its own copy of the matrix, predicts each transformed point and
// compares every accepted result, field by field, against the oldest request.
// ----------------------------------------------------------------------------
module apt2d_result_checker import apt2d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  apt2d_point_if                    pt,
  apt2d_result_if                   res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output int                        fail_count,
  output int                        pending
);

  typedef struct {
    out_t   x;
    out_t   y;
    coord_t w;
    logic   lst;
    logic   sat;
  } point_result_t;

  coef_t m_xx, m_xy, m_yx, m_yy, m_tx, m_ty;
  point_result_t transformed_q[$];
  point_result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // one product rounded half up: floor(a*c / 2^frac + 0.5)
  function automatic longint rounded_term(coord_t a, coef_t c);
    longint p;
    p = longint'(a) * longint'(c) + (longint'(1) <<< (COEF_FRAC_BITS - 1));
    return p >>> COEF_FRAC_BITS;
  endfunction

  function automatic out_t clamp_coord(longint s, inout logic sat);
    if (s > longint'(OUT_HI)) begin
      sat = 1'b1;
      return OUT_HI;
    end
    if (s < longint'(OUT_LO)) begin
      sat = 1'b1;
      return OUT_LO;
    end
    return out_t'(s);
  endfunction

  function automatic point_result_t transform_point(coord_t x, coord_t y, coord_t w,
                                                     logic lst);
    point_result_t r;
    logic sat;
    sat = 1'b0;
    r.x = clamp_coord(rounded_term(x, m_xx) + rounded_term(y, m_yx) +
                      rounded_term(w, m_tx), sat);
    r.y = clamp_coord(rounded_term(x, m_xy) + rounded_term(y, m_yy) +
                      rounded_term(w, m_ty), sat);
    r.w   = w;
    r.lst = lst;
    r.sat = sat;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] exp_v,
                                      logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_xx = COEF_ONE;
      m_xy = '0;
      m_yx = '0;
      m_yy = COEF_ONE;
      m_tx = '0;
      m_ty = '0;
      transformed_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (transformed_q.size() == 0) begin
          $display("%0t ns: result with no request pending, x_out %0d y_out %0d",
                   $time, res.x_out, res.y_out);
          fail_count++;
        end else begin
          want = transformed_q.pop_front();
          check_field("x_out", want.x, res.x_out);
          check_field("y_out", want.y, res.y_out);
          check_field("w_out", want.w, res.w_out);
          check_field("last_point_out", want.lst, res.last_point_out);
          check_field("saturated", want.sat, res.saturated);
        end
      end
      if (pt.valid && pt.ready)
        transformed_q.push_back(transform_point(pt.x_in, pt.y_in, pt.w_in,
                                                pt.last_point));
      // indexes past the last register are ignored, upper data bits dropped
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]))
          REG_COEF_XX: m_xx = coef_t'(pwdata[COEF_WIDTH-1:0]);
          REG_COEF_XY: m_xy = coef_t'(pwdata[COEF_WIDTH-1:0]);
          REG_COEF_YX: m_yx = coef_t'(pwdata[COEF_WIDTH-1:0]);
          REG_COEF_YY: m_yy = coef_t'(pwdata[COEF_WIDTH-1:0]);
          REG_TRANS_X: m_tx = coef_t'(pwdata[COEF_WIDTH-1:0]);
          REG_TRANS_Y: m_ty = coef_t'(pwdata[COEF_WIDTH-1:0]);
          default: ;
        endcase
      end
    end
    pending = transformed_q.size();
  end

endmodule

// ----- tb/affine_point_transform_2d_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_transform_2d_top_tb
// Drives points and matrix writes into the affine point transform: directed
// extremes, saturation and rounding ties, then random matrices and points
// under three idling patterns and one long result stall. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module affine_point_transform_2d_top_tb;
  import apt2d_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int BLOCK_ITEMS  = 100;
  localparam int NUM_BLOCKS   = 12;

  localparam logic [REG_IDX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [REG_IDX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

  localparam coef_t  COEF_MAX  = 24'sh7FFFFF;
  localparam coef_t  COEF_MIN  = {1'b1, 23'd0};
  localparam coef_t  COEF_HALF = 24'sh008000;
  localparam coord_t CRD_MAX   = 16'sh7FFF;
  localparam coord_t CRD_MIN   = {1'b1, 15'd0};

  typedef enum int {MAT_ANY, MAT_SCALE, MAT_EXTREME} mat_kind_t;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  bit          hold_taken;
  int unsigned cycle_cnt = 0;

  apt2d_point_if  pt_ch ();
  apt2d_result_if res_ch ();

  affine_point_transform_2d_top u_top (
    .clk     (clk),
    .rst     (rst),
    .pt      (pt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  apt2d_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .pt         (pt_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold while points keep coming
  initial begin
    res_ch.ready = 1'b0;
    hold_taken   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // setup at the current falling edge, access at the next; psel stays up
  // between back-to-back writes
  task automatic apb_write(input logic [REG_IDX_WIDTH-1:0] idx, input coef_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {8'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_matrix(input coef_t xx, input coef_t xy, input coef_t yx,
                              input coef_t yy, input coef_t tx, input coef_t ty);
    apb_write(REG_COEF_XX, xx);
    apb_write(REG_SPARE_6, coef_t'($urandom));
    apb_write(REG_COEF_XY, xy);
    apb_write(REG_COEF_YX, yx);
    apb_write(REG_COEF_YY, yy);
    apb_write(REG_SPARE_7, coef_t'($urandom));
    apb_write(REG_TRANS_X, tx);
    apb_write(REG_TRANS_Y, ty);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_point(input coord_t x, input coord_t y, input coord_t w,
                            input logic lst);
    logic accepted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pt_ch.valid      <= 1'b1;
    pt_ch.x_in       <= x;
    pt_ch.y_in       <= y;
    pt_ch.w_in       <= w;
    pt_ch.last_point <= lst;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk);
      accepted = pt_ch.ready;
      @(negedge clk);
    end
  endtask

  // stop offering points and let every pending result come out
  task automatic drain();
    pt_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return CRD_MIN;
      1:       return CRD_MAX;
      2:       return coord_t'(int'($urandom_range(0, 8)) - 4);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef(mat_kind_t kind);
    case (kind)
      MAT_ANY:   return coef_t'($urandom);
      MAT_SCALE: return coef_t'(int'($urandom_range(0, 262143)) - 131072);
      default: begin
        case ($urandom_range(0, 5))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return '0;
          3:       return COEF_ONE;
          4:       return -COEF_ONE;
          default: return COEF_HALF;
        endcase
      end
    endcase
  endfunction

  initial begin
    mat_kind_t kind;
    coord_t    w;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    pt_ch.valid      = 1'b0;
    pt_ch.x_in       = '0;
    pt_ch.y_in       = '0;
    pt_ch.w_in       = '0;
    pt_ch.last_point = 1'b0;
    hold_req         = 1'b0;
    send_idle_pct    = 23;
    recv_idle_pct    = 60;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity matrix out of reset, coordinate extremes
    send_point(16'sd0, 16'sd0, 16'sd1, 1'b0);
    send_point(CRD_MAX, CRD_MIN, 16'sd1, 1'b1);
    send_point(CRD_MIN, CRD_MAX, CRD_MIN, 1'b0);
    send_point(-16'sd1, 16'sd1, CRD_MAX, 1'b1);
    drain();

    // largest coefficients: clamp high and low
    write_matrix(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_point(CRD_MAX, CRD_MAX, CRD_MAX, 1'b0);
    send_point(CRD_MIN, CRD_MIN, CRD_MIN, 1'b1);
    send_point(16'sd1, 16'sd1, 16'sd1, 1'b0);
    drain();

    write_matrix(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_point(CRD_MIN, CRD_MIN, CRD_MIN, 1'b0);
    send_point(CRD_MAX, CRD_MAX, CRD_MAX, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
    drain();

    // half-unit coefficients: rounding ties must go toward plus infinity
    write_matrix(COEF_HALF, -COEF_HALF, COEF_ONE + COEF_HALF, COEF_HALF,
                 COEF_HALF, -COEF_HALF);
    send_point(16'sd1, 16'sd1, 16'sd1, 1'b0);
    send_point(-16'sd1, -16'sd1, -16'sd1, 1'b1);
    send_point(16'sd3, -16'sd3, 16'sd1, 1'b0);
    send_point(-16'sd3, 16'sd3, -16'sd1, 1'b0);
    send_point(16'sd1, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd1, 16'sd0, 1'b0);
    drain();

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      case (blk / 4)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      kind = mat_kind_t'(blk % 3);
      write_matrix(rand_coef(kind), rand_coef(kind), rand_coef(kind),
                   rand_coef(kind), rand_coef(kind), rand_coef(kind));
      // no idling anywhere else here, so the pipe fills and stalls the input
      if (blk == 8)
        hold_req = 1'b1;
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        w = ($urandom_range(0, 1) == 0) ? 16'sd1 : rand_coord();
        send_point(rand_coord(), rand_coord(), w, $urandom_range(0, 7) == 0);
      end
      drain();
    end

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
